// ===== rtl/core/skw_pkg.sv =====
// Shared types, codes and keyword tables of the SQL keyword tokenizer.
package skw_pkg;

	localparam int LEN_W = 6;
	localparam int NUM_KW = 5;

	typedef enum logic [2:0] {
		KIND_KEYWORD = 3'd0,
		KIND_IDENT   = 3'd1,
		KIND_LPAREN  = 3'd2,
		KIND_RPAREN  = 3'd3,
		KIND_COMMA   = 3'd4,
		KIND_EQUAL   = 3'd5,
		KIND_END     = 3'd6
	} kind_t;

	localparam logic [2:0] KW_CREATE = 3'd0;
	localparam logic [2:0] KW_TABLE  = 3'd1;
	localparam logic [2:0] KW_INTO   = 3'd2;
	localparam logic [2:0] KW_VALUES = 3'd3;
	localparam logic [2:0] KW_DROP   = 3'd4;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// One flush order: an optional held word followed by an optional punctuation token.
	typedef struct packed {
		logic             bank;
		logic [LEN_W-1:0] len;
		logic             is_kw;
		logic [2:0]       kw_id;
		logic             trunc;
		logic             has_punct;
		kind_t            punct_kind;
	} cmd_t;

	// Character write into the word buffer.
	typedef struct packed {
		logic             en;
		logic             bank;
		logic [LEN_W-1:0] idx;
		logic [7:0]       data;
	} wr_t;

	// Word buffer bank handed back by the back end.
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

	function automatic logic [LEN_W-1:0] kw_len(input logic [2:0] k);
		logic [LEN_W-1:0] r;
		case (k)
			KW_CREATE: r = LEN_W'(6);
			KW_TABLE:  r = LEN_W'(5);
			KW_INTO:   r = LEN_W'(4);
			KW_VALUES: r = LEN_W'(6);
			KW_DROP:   r = LEN_W'(4);
			default:   r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
		logic [47:0] s;
		logic [7:0]  r;
		case (k)
			KW_CREATE: s = {"e", "t", "a", "e", "r", "c"};
			KW_TABLE:  s = {8'h00, "e", "l", "b", "a", "t"};
			KW_INTO:   s = {8'h00, 8'h00, "o", "t", "n", "i"};
			KW_VALUES: s = {"s", "e", "u", "l", "a", "v"};
			KW_DROP:   s = {8'h00, 8'h00, "p", "o", "r", "d"};
			default:   s = '0;
		endcase
		case (p)
			3'd0:    r = s[7:0];
			3'd1:    r = s[15:8];
			3'd2:    r = s[23:16];
			3'd3:    r = s[31:24];
			3'd4:    r = s[39:32];
			3'd5:    r = s[47:40];
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/sql_keyword_tokenizer.sv =====
// A word character gives no result until its delimiter; a delimiter's first result passes
// the order queue and then the output register before it shows on m_tvalid. Input takes one
// character per cycle, stalling only when both word banks or both queue slots are taken. The
// back end drains one result per cycle while m_tready is high.
// Reset: arst_n clears lengths, bank ownership, queue and output valid; buffer data is kept.
module sql_keyword_tokenizer import skw_pkg::*; #(
	parameter int MAX_WORD = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] ch
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [2:0] keyword_id, [10:3] text_char, [11] token_end,
	                              // [12] truncated, [15:13] zero
	output logic [2:0]  m_tuser,  // [2:0] kind
	output logic        m_tlast
);

	// Front end owns one word bank at a time; a delimiter hands the filled bank to
	// the back end through the order queue and switches to the other bank.
	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_empty;
	cmd_t       q_cmd;
	cmd_t       q_head;
	wr_t        wr;
	rel_t       rel;
	logic [1:0] busy;

	skw_front #(.MAX_WORD(MAX_WORD)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd),
		.wr       (wr),
		.rel      (rel),
		.busy     (busy)
	);

	// Orders wait here so the front end keeps taking characters while results drain.
	skw_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	// Back end reads the held word one character per cycle into the output register, unless the output stalls.
	skw_back #(.MAX_WORD(MAX_WORD)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.head     (q_head),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.rel      (rel),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Never push an order into a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full)) else $error("order pushed into full queue");

	// Never pop an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty)) else $error("order popped from empty queue");

	// Never write a bank the back end still owns.
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !busy[wr.bank]) else $error("write into bank still being drained");

	// Punctuation tokens are single results that close both token and flush order.
	a_punct_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != KIND_KEYWORD && m_tuser != KIND_IDENT)
		|-> (m_tlast && m_tdata[11])) else $error("punctuation result not closing");

endmodule

// ===== rtl/core/skw_front.sv =====
// Front end: accepts characters, gathers words, matches keywords, issues flush orders.
module skw_front import skw_pkg::*; #(
	parameter int MAX_WORD = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] ch
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_cmd,
	output wr_t        wr,
	input  rel_t       rel,
	output logic [1:0] busy
);

	logic [LEN_W-1:0]  len_q;
	logic              ovf_q;
	logic [NUM_KW-1:0] mv_q;
	logic [NUM_KW-1:0] mv_next;
	logic              wbank_q;
	logic [1:0]        busy_q;
	logic [1:0]        busy_d;
	logic              is_delim;
	logic              has_punct;
	kind_t             pkind;
	logic              room;
	logic              need_push;
	logic              acc;
	logic              is_kw;
	logic [2:0]        kw_id;

	always_comb begin
		is_delim  = 1'b1;
		has_punct = 1'b1;
		pkind     = KIND_END;
		case (s_tdata)
			CH_LPAREN: pkind = KIND_LPAREN;
			CH_RPAREN: pkind = KIND_RPAREN;
			CH_COMMA:  pkind = KIND_COMMA;
			CH_EQUAL:  pkind = KIND_EQUAL;
			CH_SEMI:   pkind = KIND_END;
			CH_SPACE:  has_punct = 1'b0;
			default: begin
				is_delim  = 1'b0;
				has_punct = 1'b0;
			end
		endcase
	end

	// Running per-keyword match over the characters held so far.
	always_comb begin
		for (int k = 0; k < NUM_KW; k++) begin
			mv_next[k] = mv_q[k] && (len_q < LEN_W'(6)) &&
				(s_tdata == kw_char(3'(k), len_q[2:0]));
		end
	end

	always_comb begin
		is_kw = 1'b0;
		kw_id = '0;
		for (int k = 0; k < NUM_KW; k++) begin
			if (!is_kw && !ovf_q && mv_q[k] && (len_q == kw_len(3'(k)))) begin
				is_kw = 1'b1;
				kw_id = 3'(k);
			end
		end
	end

	assign room      = len_q < LEN_W'(MAX_WORD);
	assign need_push = has_punct || (len_q != '0);
	assign s_tready  = is_delim ? (!need_push || !q_full) : (!room || !busy_q[wbank_q]);
	assign acc       = s_tvalid && s_tready;
	assign q_push    = acc && is_delim && need_push;
	assign busy      = busy_q;

	always_comb begin
		q_cmd.bank       = wbank_q;
		q_cmd.len        = len_q;
		q_cmd.is_kw      = is_kw;
		q_cmd.kw_id      = is_kw ? kw_id : 3'd0;
		q_cmd.trunc      = ovf_q;
		q_cmd.has_punct  = has_punct;
		q_cmd.punct_kind = pkind;
	end

	always_comb begin
		wr.en   = acc && !is_delim && room;
		wr.bank = wbank_q;
		wr.idx  = len_q;
		wr.data = s_tdata;
	end

	// Hand back a drained bank and claim the filled one on a flush.
	always_comb begin
		busy_d = busy_q;
		if (rel.valid) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (acc && is_delim && (len_q != '0)) begin
			busy_d[wbank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			ovf_q   <= 1'b0;
			mv_q    <= '1;
			wbank_q <= 1'b0;
			busy_q  <= '0;
		end else begin
			busy_q <= busy_d;
			if (acc && is_delim) begin
				len_q <= '0;
				ovf_q <= 1'b0;
				mv_q  <= '1;
				if (len_q != '0) begin
					wbank_q <= !wbank_q;
				end
			end else if (acc) begin
				if (room) begin
					len_q <= len_q + LEN_W'(1);
					mv_q  <= mv_next;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/core/skw_cmdq.sv =====
// Two-entry queue of flush orders between the front and back ends.
module skw_cmdq import skw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	cmd_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wp_q <= !wp_q;
			end
			if (pop && !empty) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end

endmodule

// ===== rtl/core/skw_back.sv =====
// Back end: double-banked word buffer and result sequencer with output register.
module skw_back import skw_pkg::*; #(
	parameter int MAX_WORD = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  wr_t         wr,
	input  cmd_t        head,
	input  logic        q_empty,
	output logic        q_pop,
	output rel_t        rel,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [2:0] keyword_id, [10:3] text_char, [11] token_end,
	                              // [12] truncated, [15:13] zero
	output logic [2:0]  m_tuser,  // [2:0] kind
	output logic        m_tlast
);

	localparam int AW = $clog2(MAX_WORD);
	localparam int DEPTH = 2 << AW;

	logic [7:0]       mem [DEPTH];
	logic [LEN_W-1:0] idx_q;
	logic             pdone_q;
	logic             ov_q;
	logic [7:0]       rdata_q;
	logic             word_s;
	kind_t            kind_q;
	logic [2:0]       kid_q;
	logic             tend_q;
	logic             trunc_q;
	logic             last_q;
	logic             adv;
	logic             emit;
	logic             word_ph;
	logic             last_char;

	assign adv       = !ov_q || m_tready;
	assign emit      = adv && !q_empty;
	assign word_ph   = !pdone_q && (head.len != '0);
	assign last_char = idx_q == (head.len - LEN_W'(1));
	assign q_pop     = emit && (!word_ph || (last_char && !head.has_punct));
	assign rel.valid = emit && word_ph && last_char;
	assign rel.bank  = head.bank;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[{wr.bank, wr.idx[AW-1:0]}] <= wr.data;
		end
		if (emit && word_ph) begin
			rdata_q <= mem[{head.bank, idx_q[AW-1:0]}];
		end
		if (emit) begin
			word_s  <= word_ph;
			kind_q  <= word_ph ? (head.is_kw ? KIND_KEYWORD : KIND_IDENT) : head.punct_kind;
			kid_q   <= word_ph ? head.kw_id : 3'd0;
			tend_q  <= word_ph ? last_char : 1'b1;
			trunc_q <= word_ph ? head.trunc : 1'b0;
			last_q  <= word_ph ? (last_char && !head.has_punct) : 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			pdone_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (adv) begin
				ov_q <= emit;
			end
			if (emit) begin
				if (word_ph && !last_char) begin
					idx_q <= idx_q + LEN_W'(1);
				end else if (word_ph) begin
					idx_q   <= '0;
					pdone_q <= head.has_punct;
				end else begin
					idx_q   <= '0;
					pdone_q <= 1'b0;
				end
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {3'b000, trunc_q, tend_q, (word_s ? rdata_q : 8'h00), kid_q};

endmodule

// ===== tb/tokenizer_checker.sv =====
// Checker for the SQL keyword tokenizer: watches both streams, predicts tokens and compares.
`timescale 1ns / 1ps

module tokenizer_checker import skw_pkg::*; #(
	parameter int MAX_WORD = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [2:0] keyword_id, [10:3] text_char, [11] token_end,
	                               // [12] truncated, [15:13] zero
	input  logic [2:0]  m_tuser,   // [2:0] kind
	input  logic        m_tlast,
	input  logic        end_check,
	output int          fail_count,
	output int          pending,
	output int          checked,
	output int          keywords_seen
);

	typedef struct packed {
		kind_t      kind;
		logic [2:0] kw_id;
		logic [7:0] text;
		logic       tend;
		logic       trunc;
		logic       last;
	} token_beat_t;

	token_beat_t expected_tokens[$];
	logic [7:0]  word_buf[MAX_WORD];
	int          word_len;
	bit          word_ovf;
	bit          end_done;

	function automatic string keyword_spelling(input logic [2:0] id);
		case (id)
			KW_CREATE: return "create";
			KW_TABLE:  return "table";
			KW_INTO:   return "into";
			KW_VALUES: return "values";
			KW_DROP:   return "drop";
			default:   return "";
		endcase
	endfunction

	// Index of the keyword the held word spells, or -1.
	function automatic int keyword_index();
		string spell;
		bit    same;
		if (word_ovf)
			return -1;
		for (int k = KW_CREATE; k <= KW_DROP; k++) begin
			spell = keyword_spelling(3'(k));
			if (spell.len() == word_len) begin
				same = 1'b1;
				for (int i = 0; i < word_len; i++)
					if (word_buf[i] != spell.getc(i))
						same = 1'b0;
				if (same)
					return k;
			end
		end
		return -1;
	endfunction

	task automatic report(input string msg);
		$display("%0t ns  MISMATCH: %s", $time, msg);
		fail_count++;
	endtask

	// Absorb one character; queue the tokens a delimiter flushes out.
	task automatic predict_tokens(input logic [7:0] c);
		kind_t       punct;
		bit          has_punct;
		int          kw;
		token_beat_t b;
		has_punct = 1'b1;
		punct = KIND_END;
		case (c)
			CH_LPAREN: punct = KIND_LPAREN;
			CH_RPAREN: punct = KIND_RPAREN;
			CH_COMMA:  punct = KIND_COMMA;
			CH_EQUAL:  punct = KIND_EQUAL;
			CH_SEMI:   punct = KIND_END;
			CH_SPACE:  has_punct = 1'b0;
			default: begin
				if (word_len < MAX_WORD) begin
					word_buf[word_len] = c;
					word_len++;
				end else begin
					word_ovf = 1'b1;
				end
				return;
			end
		endcase
		kw = keyword_index();
		for (int i = 0; i < word_len; i++) begin
			b.kind  = (kw >= 0) ? KIND_KEYWORD : KIND_IDENT;
			b.kw_id = (kw >= 0) ? 3'(kw) : 3'd0;
			b.text  = word_buf[i];
			b.tend  = (i == word_len - 1);
			b.trunc = word_ovf;
			b.last  = (i == word_len - 1) && !has_punct;
			expected_tokens.push_back(b);
		end
		if (has_punct) begin
			b = '{kind: punct, kw_id: 3'd0, text: 8'd0, tend: 1'b1, trunc: 1'b0, last: 1'b1};
			expected_tokens.push_back(b);
		end
		word_len = 0;
		word_ovf = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_beat_t want;
		if (!arst_n) begin
			expected_tokens.delete();
			word_len      = 0;
			word_ovf      = 1'b0;
			end_done      = 1'b0;
			fail_count    = 0;
			checked       = 0;
			keywords_seen = 0;
			pending      <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_tokens(s_tdata);
			if (m_tvalid && m_tready) begin
				checked++;
				if (expected_tokens.size() == 0) begin
					report($sformatf("result %0d arrived with nothing expected", checked));
				end else begin
					want = expected_tokens.pop_front();
					if (want.kind == KIND_KEYWORD && want.tend)
						keywords_seen++;
					if (m_tuser !== want.kind)
						report($sformatf("result %0d kind %0h, expected %0h",
							checked, m_tuser, want.kind));
					if (m_tdata[2:0] !== want.kw_id)
						report($sformatf("result %0d keyword_id %0h, expected %0h",
							checked, m_tdata[2:0], want.kw_id));
					if (m_tdata[10:3] !== want.text)
						report($sformatf("result %0d text_char %0h, expected %0h",
							checked, m_tdata[10:3], want.text));
					if (m_tdata[11] !== want.tend)
						report($sformatf("result %0d token_end %0b, expected %0b",
							checked, m_tdata[11], want.tend));
					if (m_tdata[12] !== want.trunc)
						report($sformatf("result %0d truncated %0b, expected %0b",
							checked, m_tdata[12], want.trunc));
					if (m_tlast !== want.last)
						report($sformatf("result %0d last %0b, expected %0b",
							checked, m_tlast, want.last));
					if (m_tdata[15:13] !== 3'd0)
						report($sformatf("result %0d pad bits %0h, expected 0",
							checked, m_tdata[15:13]));
				end
			end
			if (end_check && !end_done) begin
				end_done = 1'b1;
				if (expected_tokens.size() != 0)
					report($sformatf("%0d expected results never arrived",
						expected_tokens.size()));
			end
			pending <= expected_tokens.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Top of the tokenizer testbench: clock, reset, character stimulus, receiver and verdict.
`timescale 1ns / 1ps

module tb_top;
	import skw_pkg::*;

	localparam int MAX_WORD = 32;
	// Far above the slowest legal run: ~400 characters, each flush up to 33 results,
	// half the cycles stalled on either side, plus the long receiver hold-off.
	localparam int LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 90;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;   // [2:0] keyword_id, [10:3] text_char, [11] token_end,
	                        // [12] truncated, [15:13] zero
	logic [2:0]  m_tuser;   // [2:0] kind
	logic        m_tlast;

	logic end_check = 1'b0;
	logic hold_req = 1'b0;
	int   stall_pct = 0;     // receiver stall rate in percent
	int   gap_pct = 0;       // sender idle rate in percent, used only by the stimulus process
	int   hold_left = 0;
	int   cycle_count = 0;
	int   chars_sent = 0;
	int   fail_count;
	int   pending;
	int   checked;
	int   keywords_seen;

	sql_keyword_tokenizer #(.MAX_WORD(MAX_WORD)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	tokenizer_checker #(.MAX_WORD(MAX_WORD)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.end_check     (end_check),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked),
		.keywords_seen (keywords_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Guard against a hung handshake: declare failure once the cycle budget is spent.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected", LIMIT, pending);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: random stalls at the current rate; a hold request drops tready for a
	// long counted stretch so the word banks and the flush queue fill up behind it.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (hold_req) begin
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic bit is_delim(input logic [7:0] c);
		return c == CH_SPACE || c == CH_LPAREN || c == CH_RPAREN || c == CH_COMMA ||
			c == CH_EQUAL || c == CH_SEMI;
	endfunction

	function automatic string keyword_text(input int k);
		case (k)
			KW_CREATE: return "create";
			KW_TABLE:  return "table";
			KW_INTO:   return "into";
			KW_VALUES: return "values";
			default:   return "drop";
		endcase
	endfunction

	// Mostly lowercase letters; otherwise any byte that does not end a word.
	function automatic logic [7:0] word_byte();
		logic [7:0] c;
		if ($urandom_range(99) < 60)
			return 8'h61 + 8'($urandom_range(25));
		c = 8'($urandom_range(255));
		while (is_delim(c))
			c = 8'($urandom_range(255));
		return c;
	endfunction

	// Spaces weigh heavier, as in real statement text.
	function automatic logic [7:0] pick_delim();
		case ($urandom_range(7))
			0, 1, 2: return CH_SPACE;
			3:       return CH_LPAREN;
			4:       return CH_RPAREN;
			5:       return CH_COMMA;
			6:       return CH_EQUAL;
			default: return CH_SEMI;
		endcase
	endfunction

	// Offer one character and hold it until the transaction completes; tvalid stays
	// high afterwards so back-to-back characters stream without a bubble.
	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s.getc(i));
	endtask

	// Drop tvalid and wait until every queued result has drained.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// One random fragment: mostly well-formed words closed by a delimiter, with some
	// near-miss keywords, overlong words, bare delimiters and raw noise bytes.
	task automatic send_fragment();
		int    r;
		int    n;
		string s;
		r = $urandom_range(99);
		if (r < 30) begin
			send_text(keyword_text($urandom_range(KW_CREATE, KW_DROP)));
			send_char(pick_delim());
		end else if (r < 50) begin
			n = $urandom_range(1, 8);
			repeat (n) send_char(word_byte());
			send_char(pick_delim());
		end else if (r < 58) begin
			// Almost a keyword: wrong case, one short, or one extra character.
			s = keyword_text($urandom_range(KW_CREATE, KW_DROP));
			case ($urandom_range(2))
				0:       s.putc(0, s.getc(0) - 8'd32);
				1:       s = s.substr(0, s.len() - 2);
				default: s = {s, "s"};
			endcase
			send_text(s);
			send_char(pick_delim());
		end else if (r < 63) begin
			// Straddle the word limit: exactly full, one over, and well past.
			n = $urandom_range(MAX_WORD - 2, MAX_WORD + 8);
			repeat (n) send_char(word_byte());
			send_char(pick_delim());
		end else if (r < 80) begin
			n = $urandom_range(1, 3);
			repeat (n) send_char(pick_delim());
		end else begin
			n = $urandom_range(1, 4);
			repeat (n) send_char(8'($urandom_range(255)));
		end
	endtask

	initial begin
		int target;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: keyword flushed by '(', control and top bytes as a word, every
		// punctuation kind, empty words at delimiters, bare space, space-flushed keyword.
		send_text("drop(");
		send_char(8'h00);
		send_char(8'hFF);
		send_text("),= ;into ");
		drain_results();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gap_pct = 0;  stall_pct <= 0;  end
				1: begin gap_pct = 46; stall_pct <= 0;  end
				2: begin gap_pct = 0;  stall_pct <= 46; end
				default: begin gap_pct = 26; stall_pct <= 26; end
			endcase
			if (phase == 0) begin
				// Hold off the receiver while characters keep streaming in.
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
			end
			target = chars_sent + ITEMS_PER_PHASE;
			while (chars_sent < target)
				send_fragment();
			// Close any pending word so its tokens are checked, then let the queue empty.
			send_char(CH_SEMI);
			drain_results();
		end

		// Let any trailing work settle before the leftover check.
		repeat (20) @(posedge clk);
		end_check <= 1'b1;
		repeat (2) @(posedge clk);

		$display("Covered %0d characters in four idle/stall phases with a long receiver hold-off;",
			chars_sent);
		$display("checked %0d result transactions, %0d of them ending keyword tokens.",
			checked, keywords_seen);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/skw_pkg.sv
rtl/core/skw_front.sv
rtl/core/skw_cmdq.sv
rtl/core/skw_back.sv
rtl/core/sql_keyword_tokenizer.sv
tb/tokenizer_checker.sv
tb/tb_top.sv
